@@ hdl/tafm_pkg.sv @@
// Shared types, constants and helper functions for the two-wire ADC frame master.
`default_nettype none
package tafm_pkg;

    localparam int DATA_BITS      = 24;
    localparam int DIVIDER_WIDTH  = 10;
    localparam int CONV_WIDTH     = 24;
    localparam int BYTE_WIDTH     = 8;
    localparam int INDEX_WIDTH    = 6;

    localparam logic [DIVIDER_WIDTH-1:0] HALF_PERIOD_RESET = DIVIDER_WIDTH'(40);

    // Command bytes pre-shifted one place left so the top bit lines up with clock 29
    localparam logic [BYTE_WIDTH-1:0] CMD_READ_SHIFTED  = 8'hAC;
    localparam logic [BYTE_WIDTH-1:0] CMD_WRITE_SHIFTED = 8'hCA;
    localparam int                    MSB               = BYTE_WIDTH - 1;

    // Frame lengths in clocks
    localparam logic [INDEX_WIDTH-1:0] SHORT_FRAME = INDEX_WIDTH'(27);
    localparam logic [INDEX_WIDTH-1:0] LONG_FRAME  = INDEX_WIDTH'(46);

    // Zero-based clock indexes of the register frame
    localparam logic [INDEX_WIDTH-1:0] IDX_DRIVE_FIRST      = INDEX_WIDTH'(27);
    localparam logic [INDEX_WIDTH-1:0] IDX_CMD_FIRST        = INDEX_WIDTH'(29);
    localparam logic [INDEX_WIDTH-1:0] IDX_CMD_SHIFT_LAST   = INDEX_WIDTH'(34);
    localparam logic [INDEX_WIDTH-1:0] IDX_CMD_LAST         = INDEX_WIDTH'(35);
    localparam logic [INDEX_WIDTH-1:0] IDX_TURN             = INDEX_WIDTH'(36);
    localparam logic [INDEX_WIDTH-1:0] IDX_REG_FIRST        = INDEX_WIDTH'(37);
    localparam logic [INDEX_WIDTH-1:0] IDX_REG_WSHIFT_LAST  = INDEX_WIDTH'(43);
    localparam logic [INDEX_WIDTH-1:0] IDX_REG_LAST         = INDEX_WIDTH'(44);
    localparam logic [INDEX_WIDTH-1:0] IDX_DATA_END         = INDEX_WIDTH'(DATA_BITS);

    typedef enum logic [1:0] {
        OP_NONE      = 2'd0,
        OP_READ_CONV = 2'd1,
        OP_READ_REG  = 2'd2,
        OP_WRITE_REG = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } phase_t;

    // One classified tick as it travels from the front to the engine
    typedef struct packed {
        op_t                   op;
        logic                  start;
        logic                  data_in;
        logic [BYTE_WIDTH-1:0] cmd_init;
        logic [BYTE_WIDTH-1:0] reg_init;
    } item_t;

    function automatic logic is_reg_op(input op_t op);
        return (op == OP_READ_REG) || (op == OP_WRITE_REG);
    endfunction

    function automatic logic driving(input phase_t ph, input op_t op,
                                     input logic [INDEX_WIDTH-1:0] idx);
        logic clk_active;
        clk_active = (ph == PH_HIGH) || (ph == PH_LOW);
        if (!clk_active || !is_reg_op(op))
            return 1'b0;
        if (idx >= IDX_DRIVE_FIRST && idx <= IDX_CMD_LAST)
            return 1'b1;
        return (op == OP_WRITE_REG) && (idx >= IDX_TURN) && (idx <= IDX_REG_LAST);
    endfunction

endpackage
`default_nettype wire

@@ hdl/tafm_front.sv @@
// Input side: accept ticks and classify each request before queueing it.
`default_nettype none
module tafm_front (
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     operation,
    input  wire logic [tafm_pkg::BYTE_WIDTH-1:0] write_value,
    input  wire logic                           data_in,
    input  wire logic                           q_full,
    output logic                                push,
    output tafm_pkg::item_t                     item
);

    tafm_pkg::op_t op;

    assign op       = tafm_pkg::op_t'(operation);
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        item.op      = op;
        item.start   = (op != tafm_pkg::OP_NONE);
        item.data_in = data_in;
        case (op)
            tafm_pkg::OP_READ_REG:  item.cmd_init = tafm_pkg::CMD_READ_SHIFTED;
            tafm_pkg::OP_WRITE_REG: item.cmd_init = tafm_pkg::CMD_WRITE_SHIFTED;
            default:                item.cmd_init = '0;
        endcase
        item.reg_init = (op == tafm_pkg::OP_WRITE_REG) ? write_value : '0;
    end

endmodule
`default_nettype wire

@@ hdl/tafm_queue.sv @@
// Two-entry queue between the front and the frame engine.
`default_nettype none
module tafm_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tafm_pkg::item_t  item_in,
    output logic                  full,
    input  wire logic             pop,
    output logic                  item_valid,
    output tafm_pkg::item_t       item_out
);

    tafm_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item_out   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule
`default_nettype wire

@@ hdl/tafm_engine.sv @@
// Frame engine: one tick per popped item, with a registered result stage.
`default_nettype none
module tafm_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [tafm_pkg::DIVIDER_WIDTH-1:0]  half_period,
    input  wire logic                                item_valid,
    input  wire tafm_pkg::item_t                     item,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     clock_out,
    output logic                                     data_out,
    output logic                                     data_drive,
    output logic                                     busy_res,
    output logic                                     done_res,
    output logic [tafm_pkg::CONV_WIDTH-1:0]          conversion,
    output logic [tafm_pkg::BYTE_WIDTH-1:0]          register_value
);

    localparam int DW = tafm_pkg::DIVIDER_WIDTH;
    localparam int IW = tafm_pkg::INDEX_WIDTH;
    localparam int BW = tafm_pkg::BYTE_WIDTH;
    localparam int NB = tafm_pkg::DATA_BITS;

    tafm_pkg::phase_t phase_reg, phase_next;
    tafm_pkg::op_t    op_reg, op_next;
    logic [DW-1:0]    tick_reg, tick_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [NB-1:0]    conv_shift_reg, conv_shift_next;
    logic [BW-1:0]    reg_shift_reg, reg_shift_next;
    logic [BW-1:0]    cmd_shift_reg, cmd_shift_next;
    logic [NB-1:0]    conv_result_reg, conv_result_next;
    logic [BW-1:0]    reg_result_reg, reg_result_next;
    logic             done_next;

    logic [DW:0]      half;
    logic             half_end;
    logic [IW-1:0]    frame_len;
    logic [IW:0]      idx_inc;

    logic             out_valid_reg;
    logic             clock_out_reg, clock_out_next;
    logic             data_out_reg, data_out_next;
    logic             data_drive_reg, data_drive_next;
    logic             busy_reg, busy_next;
    logic             done_reg;
    logic [tafm_pkg::CONV_WIDTH-1:0] conversion_reg, conversion_next;
    logic [BW-1:0]    register_value_reg;

    assign pop = item_valid && (!out_valid_reg || out_ready);

    // Zero half period counts as one tick
    assign half      = (half_period == '0) ? (DW+1)'(1) : {1'b0, half_period};
    assign half_end  = ({1'b0, tick_reg} + (DW+1)'(1)) >= half;
    assign frame_len = (op_reg == tafm_pkg::OP_READ_CONV) ? tafm_pkg::SHORT_FRAME
                                                          : tafm_pkg::LONG_FRAME;
    assign idx_inc   = {1'b0, idx_reg} + (IW+1)'(1);

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        op_next          = op_reg;
        tick_next        = tick_reg;
        idx_next         = idx_reg;
        conv_shift_next  = conv_shift_reg;
        reg_shift_next   = reg_shift_reg;
        cmd_shift_next   = cmd_shift_reg;
        conv_result_next = conv_result_reg;
        reg_result_next  = reg_result_reg;
        done_next        = 1'b0;
        unique case (phase_reg)
            tafm_pkg::PH_IDLE:
            begin
                if (item.start)
                begin
                    op_next         = item.op;
                    cmd_shift_next  = item.cmd_init;
                    reg_shift_next  = item.reg_init;
                    conv_shift_next = '0;
                    idx_next        = '0;
                    tick_next       = '0;
                    phase_next      = tafm_pkg::PH_WAIT;
                end
            end
            tafm_pkg::PH_WAIT:
            begin
                if (!item.data_in)
                begin
                    phase_next = tafm_pkg::PH_HIGH;
                    tick_next  = '0;
                    idx_next   = '0;
                end
            end
            tafm_pkg::PH_HIGH:
            begin
                if (half_end)
                begin
                    phase_next = tafm_pkg::PH_LOW;
                    tick_next  = '0;
                end
                else
                    tick_next = tick_reg + DW'(1);
            end
            tafm_pkg::PH_LOW:
            begin
                if (half_end)
                begin
                    tick_next = '0;
                    if (idx_reg < tafm_pkg::IDX_DATA_END)
                        conv_shift_next = {conv_shift_reg[NB-2:0], item.data_in};
                    if (tafm_pkg::is_reg_op(op_reg) && idx_reg >= tafm_pkg::IDX_CMD_FIRST
                        && idx_reg <= tafm_pkg::IDX_CMD_SHIFT_LAST)
                        cmd_shift_next = {cmd_shift_reg[BW-2:0], 1'b0};
                    if (op_reg == tafm_pkg::OP_WRITE_REG && idx_reg >= tafm_pkg::IDX_REG_FIRST
                        && idx_reg <= tafm_pkg::IDX_REG_WSHIFT_LAST)
                        reg_shift_next = {reg_shift_reg[BW-2:0], 1'b0};
                    if (op_reg == tafm_pkg::OP_READ_REG && idx_reg >= tafm_pkg::IDX_REG_FIRST
                        && idx_reg <= tafm_pkg::IDX_REG_LAST)
                        reg_shift_next = {reg_shift_reg[BW-2:0], item.data_in};
                    if (idx_inc >= {1'b0, frame_len})
                    begin
                        conv_result_next = conv_shift_next;
                        if (op_reg == tafm_pkg::OP_READ_REG)
                            reg_result_next = reg_shift_next;
                        done_next  = 1'b1;
                        phase_next = tafm_pkg::PH_IDLE;
                        idx_next   = '0;
                        op_next    = tafm_pkg::OP_NONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc[IW-1:0];
                        phase_next = tafm_pkg::PH_HIGH;
                    end
                end
                else
                    tick_next = tick_reg + DW'(1);
            end
            default:
            begin
                phase_next = tafm_pkg::PH_IDLE;
            end
        endcase
    end

    // Pin and status levels as seen after this tick
    always_comb
    begin
        clock_out_next  = (phase_next == tafm_pkg::PH_HIGH);
        data_drive_next = tafm_pkg::driving(phase_next, op_next, idx_next);
        data_out_next   = 1'b0;
        if (data_drive_next)
        begin
            if (idx_next >= tafm_pkg::IDX_CMD_FIRST && idx_next <= tafm_pkg::IDX_TURN)
                data_out_next = cmd_shift_next[tafm_pkg::MSB];
            else if (idx_next >= tafm_pkg::IDX_REG_FIRST)
                data_out_next = reg_shift_next[tafm_pkg::MSB];
        end
        busy_next       = (phase_next != tafm_pkg::PH_IDLE);
        conversion_next = tafm_pkg::CONV_WIDTH'(conv_result_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tafm_pkg::PH_IDLE;
            op_reg          <= tafm_pkg::OP_NONE;
            tick_reg        <= '0;
            idx_reg         <= '0;
            conv_shift_reg  <= '0;
            reg_shift_reg   <= '0;
            cmd_shift_reg   <= '0;
            conv_result_reg <= '0;
            reg_result_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                op_reg          <= op_next;
                tick_reg        <= tick_next;
                idx_reg         <= idx_next;
                conv_shift_reg  <= conv_shift_next;
                reg_shift_reg   <= reg_shift_next;
                cmd_shift_reg   <= cmd_shift_next;
                conv_result_reg <= conv_result_next;
                reg_result_reg  <= reg_result_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            clock_out_reg      <= clock_out_next;
            data_out_reg       <= data_out_next;
            data_drive_reg     <= data_drive_next;
            busy_reg           <= busy_next;
            done_reg           <= done_next;
            conversion_reg     <= conversion_next;
            register_value_reg <= reg_result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign clock_out      = clock_out_reg;
    assign data_out       = data_out_reg;
    assign data_drive     = data_drive_reg;
    assign busy_res       = busy_reg;
    assign done_res       = done_reg;
    assign conversion     = conversion_reg;
    assign register_value = register_value_reg;

endmodule
`default_nettype wire

@@ hdl/two_wire_adc_frame_master.sv @@
// Top level of the two-wire ADC frame master: config register, front, queue and engine.
//
//  Channel   Handshake                       Payload
//  input     in_valid / in_ready             operation, write_value, data_in
//  result    out_valid / out_ready           clock_out, data_out, data_drive, busy_res,
//                                            done_res, conversion, register_value
//  config    cfg_write_enable (no wait)      cfg_write_data (half period in ticks)
//
//  Every input transaction is one tick of the serial link and yields exactly one result
//  transaction. Throughput is one transaction per clock while out_ready holds; the
//  accepting edge writes the queue, then the pop loads the engine's result register,
//  which a stalled result holds back. The engine's tick update is the loop that sets
//  this rate. rst_n clears the frame state, the queue and the result valid flag; the
//  half period resets to 40 ticks. A stalled result holds in place while the queue
//  keeps taking transactions until both queue entries are full.
`default_nettype none
module two_wire_adc_frame_master (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_enable,
    input  wire logic [tafm_pkg::DIVIDER_WIDTH-1:0]  cfg_write_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          operation,
    input  wire logic [tafm_pkg::BYTE_WIDTH-1:0]     write_value,
    input  wire logic                                data_in,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     clock_out,
    output logic                                     data_out,
    output logic                                     data_drive,
    output logic                                     busy_res,
    output logic                                     done_res,
    output logic [tafm_pkg::CONV_WIDTH-1:0]          conversion,
    output logic [tafm_pkg::BYTE_WIDTH-1:0]          register_value
);

    // Half period of the serial clock; the user must write it only while the link is idle (not enforced here)
    logic [tafm_pkg::DIVIDER_WIDTH-1:0] half_period_reg;
    logic [tafm_pkg::DIVIDER_WIDTH-1:0] half_period_next;

    logic            q_full;
    logic            push;
    tafm_pkg::item_t front_item;
    logic            pop;
    logic            item_valid;
    tafm_pkg::item_t queue_item;

    assign half_period_next = cfg_write_enable ? cfg_write_data : half_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= tafm_pkg::HALF_PERIOD_RESET;
        else
            half_period_reg <= half_period_next;
    end

    // Front: accept the tick and decode the request into its start values
    tafm_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .write_value (write_value),
        .data_in     (data_in),
        .q_full      (q_full),
        .push        (push),
        .item        (front_item)
    );

    // Hold up to two decoded ticks so either side can stall on its own
    tafm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item_in    (front_item),
        .full       (q_full),
        .pop        (pop),
        .item_valid (item_valid),
        .item_out   (queue_item)
    );

    // Back: advance the frame by one tick per popped item and register the pin levels
    tafm_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .half_period    (half_period_reg),
        .item_valid     (item_valid),
        .item           (queue_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .clock_out      (clock_out),
        .data_out       (data_out),
        .data_drive     (data_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .conversion     (conversion),
        .register_value (register_value)
    );

endmodule
`default_nettype wire

@@ hdl/tafm_checker.sv @@
// Port-level checker for the two-wire ADC frame master, bound to the top level.
`default_nettype none
module tafm_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                cfg_write_enable,
    input wire logic [tafm_pkg::DIVIDER_WIDTH-1:0]  cfg_write_data,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic [1:0]                          operation,
    input wire logic [tafm_pkg::BYTE_WIDTH-1:0]     write_value,
    input wire logic                                data_in,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic                                clock_out,
    input wire logic                                data_out,
    input wire logic                                data_drive,
    input wire logic                                busy_res,
    input wire logic                                done_res,
    input wire logic [tafm_pkg::CONV_WIDTH-1:0]     conversion,
    input wire logic [tafm_pkg::BYTE_WIDTH-1:0]     register_value
);

    // A completed frame leaves the link idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !clock_out && !data_drive)
        else $error("frame done while link still active");

    // The data pin is only pulled high while the master drives it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_out |-> data_drive)
        else $error("data_out high while not driving");

    // Clock and drive only run inside a busy frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (clock_out || data_drive) |-> busy_res)
        else $error("pin activity outside a frame");

    // A stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(conversion)
            && $stable(register_value) && $stable(done_res))
        else $error("stalled result changed");

endmodule

bind two_wire_adc_frame_master tafm_checker u_tafm_checker (.*);
`default_nettype wire

@@ tb/adc_link_check_pkg.sv @@
// Pin-level predictor and result checker for the two-wire ADC frame master testbench.
package adc_link_check_pkg;
    import tafm_pkg::*;

    // One tick offered to the block
    typedef struct packed {
        op_t        op;
        logic [7:0] write_value;
        logic       data_in;
    } link_tick_t;

    // Pin levels and captured words reported for one tick
    typedef struct packed {
        logic        clock_out;
        logic        data_out;
        logic        data_drive;
        logic        busy;
        logic        done;
        logic [23:0] conversion;
        logic [7:0]  register_value;
    } link_pins_t;

    localparam int         CONV_BITS        = 24;
    localparam int         CONV_ONLY_CLOCKS = 27;
    localparam int         REG_FRAME_CLOCKS = 46;
    localparam logic [7:0] READ_COMMAND     = {7'h56, 1'b0};
    localparam logic [7:0] WRITE_COMMAND    = {7'h65, 1'b0};
    localparam int         LOW_DRIVE_FIRST  = 27;
    localparam int         COMMAND_FIRST    = 29;
    localparam int         COMMAND_SHIFT_TO = 34;
    localparam int         COMMAND_LAST     = 35;
    localparam int         TURNAROUND       = 36;
    localparam int         BYTE_FIRST       = 37;
    localparam int         BYTE_SHIFT_TO    = 43;
    localparam int         BYTE_LAST        = 44;
    localparam int         REPORT_LIMIT     = 10;

    class link_pin_checker;
        phase_t      link_phase;
        int          tick_count;
        int          clock_index;
        op_t         frame_op;
        logic [23:0] conv_shift;
        logic [7:0]  reg_shift;
        logic [7:0]  cmd_shift;
        logic [23:0] conv_latched;
        logic [7:0]  reg_latched;
        logic [9:0]  half_period;
        link_pins_t  expected_pins[$];
        int          mismatches;
        int          results_seen;

        function new();
            link_phase   = PH_IDLE;
            tick_count   = 0;
            clock_index  = 0;
            frame_op     = OP_NONE;
            conv_shift   = '0;
            reg_shift    = '0;
            cmd_shift    = '0;
            conv_latched = '0;
            reg_latched  = '0;
            half_period  = 10'd40;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_half_period(logic [9:0] value);
            half_period = value;
        endfunction

        function bit link_idle();
            return link_phase == PH_IDLE;
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction

        function int failures();
            return mismatches;
        endfunction

        function bit pin_driven();
            bit reg_frame;
            reg_frame = (frame_op == OP_READ_REG) || (frame_op == OP_WRITE_REG);
            if ((link_phase != PH_HIGH && link_phase != PH_LOW) || !reg_frame)
                return 1'b0;
            if (clock_index >= LOW_DRIVE_FIRST && clock_index <= COMMAND_LAST)
                return 1'b1;
            return frame_op == OP_WRITE_REG && clock_index >= TURNAROUND &&
                   clock_index <= BYTE_LAST;
        endfunction

        // Advance the link by one tick and queue the pins it should show afterwards
        function void note_tick(link_tick_t t);
            link_pins_t p;
            bit         frame_done;
            bit         reg_frame;
            int         half;
            int         total;
            frame_done = 1'b0;
            half = (half_period == 10'd0) ? 1 : int'(half_period);
            case (link_phase)
                PH_IDLE: begin
                    if (t.op != OP_NONE) begin
                        frame_op    = t.op;
                        cmd_shift   = (t.op == OP_READ_REG)  ? READ_COMMAND :
                                      (t.op == OP_WRITE_REG) ? WRITE_COMMAND : 8'h00;
                        reg_shift   = (t.op == OP_WRITE_REG) ? t.write_value : 8'h00;
                        conv_shift  = '0;
                        clock_index = 0;
                        tick_count  = 0;
                        link_phase  = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (!t.data_in) begin
                        link_phase  = PH_HIGH;
                        tick_count  = 0;
                        clock_index = 0;
                    end
                end
                PH_HIGH: begin
                    if (tick_count + 1 >= half) begin
                        link_phase = PH_LOW;
                        tick_count = 0;
                    end else begin
                        tick_count++;
                    end
                end
                default: begin
                    if (tick_count + 1 >= half) begin
                        tick_count = 0;
                        reg_frame  = (frame_op == OP_READ_REG) || (frame_op == OP_WRITE_REG);
                        total      = (frame_op == OP_READ_CONV) ? CONV_ONLY_CLOCKS
                                                                : REG_FRAME_CLOCKS;
                        if (clock_index < CONV_BITS)
                            conv_shift = {conv_shift[22:0], t.data_in};
                        if (reg_frame && clock_index >= COMMAND_FIRST &&
                            clock_index <= COMMAND_SHIFT_TO)
                            cmd_shift = {cmd_shift[6:0], 1'b0};
                        if (frame_op == OP_WRITE_REG && clock_index >= BYTE_FIRST &&
                            clock_index <= BYTE_SHIFT_TO)
                            reg_shift = {reg_shift[6:0], 1'b0};
                        if (frame_op == OP_READ_REG && clock_index >= BYTE_FIRST &&
                            clock_index <= BYTE_LAST)
                            reg_shift = {reg_shift[6:0], t.data_in};
                        if (clock_index + 1 >= total) begin
                            conv_latched = conv_shift;
                            if (frame_op == OP_READ_REG)
                                reg_latched = reg_shift;
                            frame_done  = 1'b1;
                            link_phase  = PH_IDLE;
                            clock_index = 0;
                            frame_op    = OP_NONE;
                        end else begin
                            clock_index++;
                            link_phase = PH_HIGH;
                        end
                    end else begin
                        tick_count++;
                    end
                end
            endcase
            p.clock_out  = (link_phase == PH_HIGH);
            p.data_drive = pin_driven();
            if (!p.data_drive)
                p.data_out = 1'b0;
            else if (clock_index >= COMMAND_FIRST && clock_index <= TURNAROUND)
                p.data_out = cmd_shift[7];
            else if (clock_index >= BYTE_FIRST)
                p.data_out = reg_shift[7];
            else
                p.data_out = 1'b0;
            p.busy           = (link_phase != PH_IDLE);
            p.done           = frame_done;
            p.conversion     = conv_latched;
            p.register_value = reg_latched;
            expected_pins.push_back(p);
        endfunction

        function void check_pins(link_pins_t got);
            link_pins_t want;
            results_seen++;
            if (expected_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected: %p", results_seen, got);
                return;
            end
            want = expected_pins.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result %0d mismatch: exp clk=%b dout=%b drv=%b busy=%b done=%b",
                              " conv=%06h reg=%02h | got clk=%b dout=%b drv=%b busy=%b",
                              " done=%b conv=%06h reg=%02h"},
                             results_seen, want.clock_out, want.data_out, want.data_drive,
                             want.busy, want.done, want.conversion, want.register_value,
                             got.clock_out, got.data_out, got.data_drive, got.busy,
                             got.done, got.conversion, got.register_value);
            end
        endfunction
    endclass

endpackage

@@ tb/two_wire_adc_frame_master_tb.sv @@
// Top-level testbench for the two-wire ADC frame master: stimulus, handshakes and checking.
module two_wire_adc_frame_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tafm_pkg::*;
    import adc_link_check_pkg::*;

    // Longest quiet stretch of a correct run is the receiver hold-off plus a few random
    // stalls around it; the limit takes that several times over.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TICKS_PER_STEP  = 30;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [9:0]  cfg_write_data   = 10'd0;
    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic [1:0]  operation        = 2'd0;
    logic [7:0]  write_value      = 8'd0;
    logic        data_in          = 1'b1;
    logic        out_valid;
    logic        out_ready        = 1'b0;
    logic        clock_out;
    logic        data_out;
    logic        data_drive;
    logic        busy_res;
    logic        done_res;
    logic [23:0] conversion;
    logic [7:0]  register_value;

    link_pin_checker board;
    link_tick_t      directed_q[$];
    int              send_idle_pct   = 0;
    int              recv_idle_pct   = 0;
    bit              hold_off_request = 1'b0;
    int              hold_left       = 0;
    int              quiet_cycles    = 0;

    two_wire_adc_frame_master DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .write_value      (write_value),
        .data_in          (data_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .clock_out        (clock_out),
        .data_out         (data_out),
        .data_drive       (data_drive),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .conversion       (conversion),
        .register_value   (register_value)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: check every accepted transaction, then pick the next ready level.
    // A hold-off request drops ready for a long stretch so the queue fills and the
    // block has to stall its input.
    always @(posedge clk) begin
        if (out_valid && out_ready)
            board.check_pins({clock_out, data_out, data_drive, busy_res, done_res,
                              conversion, register_value});
        if (hold_off_request) begin
            hold_left        = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when neither channel moves a transaction for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_tick(input op_t op, input logic [7:0] value, input logic pin);
        link_tick_t t;
        t.op          = op;
        t.write_value = value;
        t.data_in     = pin;
        directed_q.push_back(t);
    endtask

    // Random tick: requests mostly land while idle; while busy they are ignored noise
    function automatic link_tick_t random_tick();
        link_tick_t t;
        if (board.link_idle())
            t.op = ($urandom_range(3) == 0) ? OP_NONE : op_t'($urandom_range(1, 3));
        else
            t.op = op_t'($urandom_range(3));
        t.write_value = 8'($urandom);
        t.data_in     = 1'($urandom_range(1));
        return t;
    endfunction

    // Offer the directed list, then random_count random ticks, then, with to_idle set,
    // quiet ticks until the frame in flight is over. Valid holds with its payload until
    // the transaction goes.
    task automatic drive_ticks(input int random_count, input bit to_idle);
        link_tick_t cur;
        bit         holding;
        bit         finished;
        int         random_left;
        holding     = 1'b0;
        finished    = 1'b0;
        random_left = random_count;
        while (!finished) begin
            @(posedge clk);
            if (holding && in_ready) begin
                board.note_tick(cur);
                holding = 1'b0;
            end
            finished = !holding && directed_q.size() == 0 && random_left == 0 &&
                       (!to_idle || board.link_idle());
            if (finished) begin
                in_valid <= 1'b0;
            end else if (!holding) begin
                if ($urandom_range(99) >= send_idle_pct) begin
                    if (directed_q.size() > 0) begin
                        cur = directed_q.pop_front();
                    end else if (random_left > 0) begin
                        cur = random_tick();
                        random_left--;
                    end else begin
                        cur             = random_tick();
                        cur.op          = OP_NONE;
                    end
                    holding     = 1'b1;
                    in_valid    <= 1'b1;
                    operation   <= cur.op;
                    write_value <= cur.write_value;
                    data_in     <= cur.data_in;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Write only with the pipeline empty and no input transaction on offer
    task automatic write_half_period(input logic [9:0] value);
        wait_drained();
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        board.set_half_period(value);
    endtask

    // Short random runs under one idling plan, each at a fresh half period
    task automatic random_stretch(input int send_pct, input int recv_pct,
                                  input bit with_hold_off);
        for (int step = 0; step < 2; step++) begin
            write_half_period(($urandom_range(3) == 0) ? 10'($urandom_range(4, 6))
                                                       : 10'($urandom_range(1, 3)));
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            if (with_hold_off && step == 1)
                hold_off_request = 1'b1;
            drive_ticks(TICKS_PER_STEP, 1'b1);
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset half period of 40: a request on a tick with the pin low only latches,
        // a second request while waiting is dropped, write of all ones. Run the first
        // clocks at 40 ticks per half, then shrink the half period to end the frame.
        queue_tick(OP_NONE, 8'h00, 1'b1);
        queue_tick(OP_NONE, 8'hFF, 1'b0);
        queue_tick(OP_WRITE_REG, 8'hFF, 1'b0);
        queue_tick(OP_READ_REG, 8'h00, 1'b0);
        queue_tick(OP_READ_CONV, 8'h5A, 1'b1);
        drive_ticks(100, 1'b0);
        write_half_period(10'd1);
        drive_ticks(0, 1'b1);

        // Zero half period runs as one tick per half: register read with a wait, writes, a read
        write_half_period(10'd0);
        queue_tick(OP_READ_REG, 8'hFF, 1'b1);
        queue_tick(OP_NONE, 8'h00, 1'b1);
        queue_tick(OP_WRITE_REG, 8'h00, 1'b1);
        queue_tick(OP_NONE, 8'h00, 1'b0);
        drive_ticks(0, 1'b1);
        queue_tick(OP_WRITE_REG, 8'h00, 1'b0);
        drive_ticks(0, 1'b1);
        queue_tick(OP_WRITE_REG, 8'hA5, 1'b1);
        queue_tick(OP_NONE, 8'h00, 1'b0);
        drive_ticks(0, 1'b1);
        queue_tick(OP_READ_CONV, 8'hFF, 1'b0);
        drive_ticks(0, 1'b1);

        // Widest half period for the first clock high, then shrink it to end the read
        write_half_period(10'd1023);
        queue_tick(OP_READ_CONV, 8'h00, 1'b0);
        drive_ticks(40, 1'b0);
        write_half_period(10'd1);
        drive_ticks(0, 1'b1);

        // Shortest nonzero half period, plain read then register read
        write_half_period(10'd1);
        queue_tick(OP_READ_CONV, 8'h3C, 1'b0);
        queue_tick(OP_NONE, 8'h00, 1'b1);
        drive_ticks(0, 1'b1);
        queue_tick(OP_READ_REG, 8'hC3, 1'b0);
        drive_ticks(0, 1'b1);

        // Random traffic: receiver-heavy idling, sender-heavy idling, then none at all with a hold-off
        random_stretch(26, 73, 1'b0);
        random_stretch(73, 26, 1'b0);
        random_stretch(0, 0, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.failures() == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
